// File: src/arh_pkg.sv
// ----------------------------------------------------------------------------
// arh_pkg
// Shared widths, constants and handshake structs of the auto-range histogram.
// ----------------------------------------------------------------------------
package arh_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 7;
    localparam int CNT_W    = 11;
    localparam int IDX_W    = 6;
    localparam int NUM_W    = 23;   // (x - min) * bins, up to 65535 * 64
    localparam int QUO_W    = 7;    // quotient never exceeds 64
    localparam int STEP_W   = 3;

    localparam logic [CNT_W-1:0]    COUNT_MAX  = 11'd2047;
    localparam logic [CFG_W-1:0]    BINS_MIN   = 7'd2;
    localparam logic [CFG_W-1:0]    BINS_RESET = 7'd16;
    localparam logic [SAMPLE_W-1:0] MIN_RESET  = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] MAX_RESET  = 16'h8000;

    typedef struct packed {
        logic                start;
        logic [NUM_W-1:0]    num;
        logic [SAMPLE_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quot;
    } t_div_rsp;

endpackage

// File: src/arh_divider.sv
// ----------------------------------------------------------------------------
// arh_divider
// Restoring divider, one quotient bit per cycle, quotient below 128.
// ----------------------------------------------------------------------------
module arh_divider (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  arh_pkg::t_div_req i_req,
    output arh_pkg::t_div_rsp o_rsp
);
    import arh_pkg::*;

    logic [NUM_W-1:0]  r_rem;
    logic [SAMPLE_W-1:0] r_den;
    logic [STEP_W-1:0] r_k;
    logic [QUO_W-1:0]  r_q;
    logic              r_busy;
    logic              r_done;
    logic [NUM_W-1:0]  shifted;
    logic              fits;

    assign shifted = NUM_W'(r_den) << r_k;
    assign fits    = (r_rem >= shifted);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_k == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_k == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_den <= i_req.den;
            r_k   <= STEP_W'(QUO_W - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem    <= r_rem - shifted;
                r_q[r_k] <= 1'b1;
            end
            r_k <= r_k - STEP_W'(1);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

// File: src/auto_range_histogram_unit.sv
// ----------------------------------------------------------------------------
// auto_range_histogram_unit
// Stores a batch of samples with running min/max, then bins them into equal
// width bins over [min, max] and reports one count per bin, or one error result for an empty or flat batch.
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// input    in         i_in_valid / o_in_stall   i_sample, i_ghost, i_last_sample
// output   out        o_out_valid / i_out_stall bin index, count, range, flags
// config   in         i_cfg_we                  i_cfg_data (bins_in_use)
//
// Samples load one per cycle. At batch end each stored sample passes through
// memory read, multiply, the 7-step shared divider and counter update, then
// one result is reported per bin.
// Input is stalled for the whole binning and reporting pass.
// Reset is synchronous; no memory clearing pass, counter entries use valid bits.
// A stalled output holds the result register and the sequencer waits.
// ----------------------------------------------------------------------------
module auto_range_histogram_unit #(
    parameter int MAX_SAMPLES = 1024,
    parameter int MAX_BINS    = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [arh_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                           i_ghost,
    input  logic                           i_last_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [arh_pkg::IDX_W-1:0]      o_bin_index,
    output logic [arh_pkg::CNT_W-1:0]      o_bin_count,
    output logic signed [arh_pkg::SAMPLE_W-1:0] o_range_low,
    output logic signed [arh_pkg::SAMPLE_W-1:0] o_range_high,
    output logic                           o_range_error,
    output logic                           o_dropped,
    output logic                           o_final_bin,
    input  logic                           i_cfg_we,
    input  logic [arh_pkg::CFG_W-1:0]      i_cfg_data
);
    import arh_pkg::*;

    localparam int AW     = $clog2(MAX_SAMPLES);
    localparam int CW     = $clog2(MAX_SAMPLES + 1);
    localparam int BIN_AW = $clog2(MAX_BINS);

    typedef enum logic [8:0] {
        S_LOAD  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_ERR   = 9'b000000100,
        S_RD    = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_CRD   = 9'b001000000,
        S_CWR   = 9'b010000000,
        S_EMIT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [SAMPLE_W-1:0]        r_mem [MAX_SAMPLES];
    logic [SAMPLE_W-1:0]        r_rd_data;
    logic [CNT_W-1:0]           r_cnt_mem [MAX_BINS];
    logic [CNT_W-1:0]           r_cnt_rd;
    logic [MAX_BINS-1:0]        r_bin_vld;
    logic                       r_cnt_vld_rd;
    logic                       r_emit_rd;

    logic [CW-1:0]              r_count;
    logic [CW-1:0]              r_idx;
    logic signed [SAMPLE_W-1:0] r_min, r_max;
    logic                       r_ovf;
    logic [CFG_W-1:0]           r_cfg_bins;
    logic [CFG_W-1:0]           r_bins;
    logic [SAMPLE_W-1:0]        r_span;
    logic [BIN_AW-1:0]          r_j;
    logic [BIN_AW-1:0]          r_k;

    logic                       in_xfer, store, out_free, load_out, restart;
    logic [CFG_W-1:0]           bins_clamped;
    logic signed [SAMPLE_W:0]   span_wide, d_wide;
    logic [NUM_W-1:0]           prod;
    logic [BIN_AW-1:0]          cnt_addr;
    logic [CNT_W-1:0]           cur_cnt;
    logic                       last_bin;
    logic [QUO_W-1:0]           j_clamped;
    t_div_req                   div_req;
    t_div_rsp                   div_rsp;

    assign o_in_stall = (r_state != S_LOAD);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign store      = in_xfer && !i_ghost && (r_count < CW'(MAX_SAMPLES));
    assign out_free   = !o_out_valid || !i_out_stall;

    assign bins_clamped = (r_cfg_bins < BINS_MIN) ? BINS_MIN :
                          (r_cfg_bins > CFG_W'(MAX_BINS)) ? CFG_W'(MAX_BINS) : r_cfg_bins;

    assign span_wide = {r_max[SAMPLE_W-1], r_max} - {r_min[SAMPLE_W-1], r_min};
    assign d_wide    = {r_rd_data[SAMPLE_W-1], r_rd_data} - {r_min[SAMPLE_W-1], r_min};
    assign prod      = NUM_W'(d_wide[SAMPLE_W-1:0]) * NUM_W'(r_bins);

    assign div_req.start = (r_state == S_MUL);
    assign div_req.num   = prod;
    assign div_req.den   = r_span;

    arh_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign j_clamped = (div_rsp.quot >= r_bins) ? (r_bins - QUO_W'(1)) : div_rsp.quot;
    assign cnt_addr  = (r_state == S_CRD) ? r_j : r_k;
    assign cur_cnt   = r_cnt_vld_rd ? r_cnt_rd : '0;
    assign last_bin  = (CFG_W'(r_k) == (r_bins - CFG_W'(1)));
    assign load_out  = ((r_state == S_ERR) || (r_state == S_EMIT && r_emit_rd)) && out_free;
    assign restart   = load_out && ((r_state == S_ERR) || last_bin);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:  if (in_xfer && i_last_sample) n_state = S_CHECK;
            S_CHECK: begin
                if (r_count == '0 || r_min == r_max) n_state = S_ERR;
                else                                 n_state = S_RD;
            end
            S_ERR:   if (load_out) n_state = S_LOAD;
            S_RD:    n_state = S_MUL;
            S_MUL:   n_state = S_DIV;
            S_DIV:   if (div_rsp.done) n_state = S_CRD;
            S_CRD:   n_state = S_CWR;
            S_CWR:   n_state = (r_idx + CW'(1) == r_count) ? S_EMIT : S_RD;
            S_EMIT:  if (restart) n_state = S_LOAD;
            default: n_state = S_LOAD;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (store) r_mem[r_count[AW-1:0]] <= i_sample;
        r_rd_data <= r_mem[r_idx[AW-1:0]];
        if (r_state == S_CWR && cur_cnt < COUNT_MAX) r_cnt_mem[r_j] <= cur_cnt + CNT_W'(1);
        r_cnt_rd     <= r_cnt_mem[cnt_addr];
        r_cnt_vld_rd <= r_bin_vld[cnt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_min       <= MIN_RESET;
            r_max       <= MAX_RESET;
            r_ovf       <= 1'b0;
            r_cfg_bins  <= BINS_RESET;
            r_bin_vld   <= '0;
            o_out_valid <= 1'b0;
            r_emit_rd   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cfg_bins <= i_cfg_data;

            if (store) begin
                r_count <= r_count + CW'(1);
                if (i_sample < r_min) r_min <= i_sample;
                if (i_sample > r_max) r_max <= i_sample;
            end else if (in_xfer && !i_ghost) begin
                r_ovf <= 1'b1;
            end

            if (r_state == S_CHECK) r_bin_vld <= '0;
            else if (r_state == S_CWR) r_bin_vld[r_j] <= 1'b1;

            // read data for bin r_k is ready in the cycle after entering a bin slot
            r_emit_rd <= (r_state == S_EMIT) && !load_out;

            if (load_out)          o_out_valid <= 1'b1;
            else if (!i_out_stall) o_out_valid <= 1'b0;

            if (restart) begin
                r_count <= '0;
                r_min   <= MIN_RESET;
                r_max   <= MAX_RESET;
                r_ovf   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_last_sample) r_bins <= bins_clamped;
        case (r_state)
            S_CHECK: begin
                r_span <= span_wide[SAMPLE_W-1:0];
                r_idx  <= '0;
                r_k    <= '0;
            end
            S_DIV:   if (div_rsp.done) r_j <= j_clamped[BIN_AW-1:0];
            S_CWR:   r_idx <= r_idx + CW'(1);
            S_EMIT:  if (load_out) r_k <= r_k + BIN_AW'(1);
            default: ;
        endcase
        if (load_out) begin
            o_dropped <= r_ovf;
            if (r_state == S_ERR) begin
                o_bin_index   <= '0;
                o_bin_count   <= '0;
                o_range_low   <= (r_count == '0) ? '0 : r_min;
                o_range_high  <= (r_count == '0) ? '0 : r_max;
                o_range_error <= 1'b1;
                o_final_bin   <= 1'b1;
            end else begin
                o_bin_index   <= IDX_W'(r_k);
                o_bin_count   <= cur_cnt;
                o_range_low   <= r_min;
                o_range_high  <= r_max;
                o_range_error <= 1'b0;
                o_final_bin   <= last_bin;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SAMPLES))
        else $error("stored count beyond capacity");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_idx < r_count))
        else $error("binning index past stored count");

    a_bin_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CWR) |-> (CFG_W'(r_j) < r_bins))
        else $error("bin index beyond bins in use");

    a_restart_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        restart |=> (r_state == S_LOAD && r_count == '0 && !r_ovf))
        else $error("batch state not restarted after final result");

    a_err_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_range_error) |-> o_final_bin)
        else $error("error result not marked final");

endmodule

// File: tb/sv/auto_range_histogram_unit_tb.sv
// ----------------------------------------------------------------------------
// auto_range_histogram_unit_tb
// Self-checking bench for the auto-range histogram. It streams batches of
// samples under several sender and receiver idle profiles, predicts every bin
// result of each batch, and checks each output transfer against the oldest
// prediction. Directed batches cover range extremes, bin count clamping,
// ghosted and empty batches and flat ranges.
// ----------------------------------------------------------------------------
module auto_range_histogram_unit_tb;
    import arh_pkg::*;

    localparam int MAX_SAMPLES = 1024;
    localparam int MAX_BINS    = 64;

    typedef struct {
        logic [IDX_W-1:0]           idx;
        logic [CNT_W-1:0]           cnt;
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        logic                       err;
        logic                       drop;
        logic                       fin;
    } t_bin_result;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       i_ghost;
    logic                       i_last_sample;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [IDX_W-1:0]           o_bin_index;
    logic [CNT_W-1:0]           o_bin_count;
    logic signed [SAMPLE_W-1:0] o_range_low;
    logic signed [SAMPLE_W-1:0] o_range_high;
    logic                       o_range_error;
    logic                       o_dropped;
    logic                       o_final_bin;
    logic                       i_cfg_we;
    logic [CFG_W-1:0]           i_cfg_data;

    auto_range_histogram_unit #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .MAX_BINS   (MAX_BINS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .i_ghost      (i_ghost),
        .i_last_sample(i_last_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_bin_index  (o_bin_index),
        .o_bin_count  (o_bin_count),
        .o_range_low  (o_range_low),
        .o_range_high (o_range_high),
        .o_range_error(o_range_error),
        .o_dropped    (o_dropped),
        .o_final_bin  (o_final_bin),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    // histogram model state
    logic signed [SAMPLE_W-1:0] batch_samples[$];
    int                         batch_min;
    int                         batch_max;
    bit                         batch_dropped;
    int                         bins_reg;
    t_bin_result                pending_bins[$];

    int error_count;
    int send_idle_pct;
    int stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic void restart_batch();
        batch_samples.delete();
        batch_min     = 32767;
        batch_max     = -32768;
        batch_dropped = 1'b0;
    endfunction

    function automatic void model_sample(logic signed [SAMPLE_W-1:0] s, logic g, logic l);
        int          b;
        int          span;
        int          j;
        int          counts[MAX_BINS];
        t_bin_result r;
        if (!g) begin
            if (batch_samples.size() < MAX_SAMPLES) begin
                batch_samples.push_back(s);
                if (s < batch_min) batch_min = s;
                if (s > batch_max) batch_max = s;
            end else begin
                batch_dropped = 1'b1;
            end
        end
        if (!l) return;
        b = bins_reg < 2 ? 2 : (bins_reg > MAX_BINS ? MAX_BINS : bins_reg);
        r.drop = batch_dropped;
        if (batch_samples.size() == 0 || batch_min == batch_max) begin
            r.idx = '0;
            r.cnt = '0;
            r.lo  = batch_samples.size() == 0 ? 16'sd0 : batch_min[SAMPLE_W-1:0];
            r.hi  = batch_samples.size() == 0 ? 16'sd0 : batch_max[SAMPLE_W-1:0];
            r.err = 1'b1;
            r.fin = 1'b1;
            pending_bins.push_back(r);
        end else begin
            foreach (counts[k]) counts[k] = 0;
            span = batch_max - batch_min;
            foreach (batch_samples[k]) begin
                j = ((int'(batch_samples[k]) - batch_min) * b) / span;
                if (j >= b) j = b - 1;   // the maximum folds into the top bin
                if (counts[j] < 2047) counts[j]++;
            end
            for (int k = 0; k < b; k++) begin
                r.idx = k[IDX_W-1:0];
                r.cnt = counts[k][CNT_W-1:0];
                r.lo  = batch_min[SAMPLE_W-1:0];
                r.hi  = batch_max[SAMPLE_W-1:0];
                r.err = 1'b0;
                r.fin = (k == b - 1);
                pending_bins.push_back(r);
            end
        end
        restart_batch();
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_bin_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bins.size() == 0) begin
                $error("unexpected result transfer, bin_index %0d", o_bin_index);
                error_count++;
            end else begin
                e = pending_bins.pop_front();
                check_field("bin_index", e.idx, o_bin_index);
                check_field("bin_count", e.cnt, o_bin_count);
                check_field("range_low", e.lo, o_range_low);
                check_field("range_high", e.hi, o_range_high);
                check_field("range_error", e.err, o_range_error);
                check_field("dropped", e.drop, o_dropped);
                check_field("final_bin", e.fin, o_final_bin);
            end
        end
    end

    task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic g, logic l);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_sample      <= s;
        i_ghost       <= g;
        i_last_sample <= l;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        model_sample(s, g, l);
    endtask

    // drain all results, then leave the block idle before touching config
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bins.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_bins(int value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        bins_reg = value & 7'h7F;
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        // reset bin count of 16
        send_sample(-16'sd32768, 1'b0, 1'b0);
        send_sample(16'sd32767, 1'b0, 1'b0);
        send_sample(16'sd0, 1'b0, 1'b1);
        set_bins(0);    // clamps to two bins
        send_sample(16'sd100, 1'b0, 1'b0);
        send_sample(16'sd1000, 1'b1, 1'b0);
        send_sample(16'sd101, 1'b0, 1'b1);
        set_bins(127);  // clamps to the maximum
        send_sample(-16'sd32768, 1'b0, 1'b0);
        send_sample(-16'sd1, 1'b0, 1'b0);
        send_sample(16'sd32767, 1'b0, 1'b0);
        send_sample(16'sd5, 1'b1, 1'b1);    // ghosted last still ends the batch
        set_bins(64);
        send_sample(-16'sd1, 1'b1, 1'b1);   // empty batch
        send_sample(16'sd7, 1'b0, 1'b0);
        send_sample(16'sd7, 1'b0, 1'b1);    // flat range
        send_sample(-16'sd9, 1'b0, 1'b1);   // single sample
        set_bins(2);
        send_sample(-16'sd3, 1'b0, 1'b0);
        send_sample(16'sd0, 1'b0, 1'b0);
        send_sample(16'sd3, 1'b0, 1'b1);
        set_bins(1);
        send_sample(16'sd0, 1'b0, 1'b0);
        send_sample(16'sd1, 1'b0, 1'b1);
    endtask

    task automatic random_batches(int idle_pct, int stall_p, int n_items);
        int sent;
        int len;
        int lo;
        int width;
        sent = 0;
        while (sent < n_items) begin
            set_bins($urandom_range(99) < 10 ? $urandom_range(0, 127)
                                             : $urandom_range(2, 64));
            send_idle_pct = idle_pct;
            stall_pct     = stall_p;
            len = $urandom_range(1, 12);
            width = $urandom_range(3) == 0 ? 65535 : $urandom_range(1, 300);
            lo = $urandom_range(0, 65535 - width) - 32768;
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(99) < 15)
                    send_sample(SAMPLE_W'($urandom), $urandom_range(99) < 70,
                                k == len - 1);
                else
                    send_sample(SAMPLE_W'(lo + $urandom_range(0, width)), 1'b0,
                                k == len - 1);
                sent++;
            end
            send_idle_pct = 0;
            stall_pct     = 0;
        end
    endtask

    task automatic test_random();
        random_batches(0, 0, 27);
        random_batches(57, 0, 27);
        random_batches(0, 57, 27);
        random_batches(37, 37, 27);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_sample      = '0;
        i_ghost       = 1'b0;
        i_last_sample = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        error_count   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        bins_reg      = 16;
        restart_batch();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        stall_pct = 0;
        wait_idle();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
